// File: hw/rtl/sha_pkg.sv
package sha_pkg;

   localparam int BlockWords = 16;
   localparam int Rounds     = 64;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_PAD    = 7'b0000010,
      ST_LOAD   = 7'b0000100,
      ST_SCHED  = 7'b0001000,
      ST_ROUND  = 7'b0010000,
      ST_UPDATE = 7'b0100000,
      ST_EMIT   = 7'b1000000
   } state_type;

   localparam logic [31:0] InitHash [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam logic [31:0] RoundK [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   localparam logic [7:0] PadByte = 8'h80;

   function automatic logic [31:0] ror(input logic [31:0] x, input int n);
      ror = (x >> n) | (x << (32 - n));
   endfunction

endpackage

// File: hw/rtl/sha_round.sv
// One SHA-256 compression round on the working variables a..h.
module sha_round
   import sha_pkg::*;
(
   input  logic [31:0] vars_in  [8],
   input  logic [31:0] k_word,
   input  logic [31:0] w_word,
   output logic [31:0] vars_out [8]
);
   logic [31:0] big1, big0, choose, major, t1;

   always_comb begin
      big1   = ror(vars_in[4], 6) ^ ror(vars_in[4], 11) ^ ror(vars_in[4], 25);
      big0   = ror(vars_in[0], 2) ^ ror(vars_in[0], 13) ^ ror(vars_in[0], 22);
      choose = (vars_in[4] & vars_in[5]) ^ (~vars_in[4] & vars_in[6]);
      major  = (vars_in[0] & vars_in[1]) ^ (vars_in[0] & vars_in[2])
             ^ (vars_in[1] & vars_in[2]);
      t1     = vars_in[7] + big1 + choose + k_word + w_word;
      vars_out[7] = vars_in[6];
      vars_out[6] = vars_in[5];
      vars_out[5] = vars_in[4];
      vars_out[4] = vars_in[3] + t1;
      vars_out[3] = vars_in[2];
      vars_out[2] = vars_in[1];
      vars_out[1] = vars_in[0];
      vars_out[0] = t1 + big0 + major;
   end
endmodule

// File: hw/rtl/sha256_stream_hasher.sv
// Channel | Dir | tdata fields (low bit up)       | tuser
// req     | in  | data_byte[7:0]                   | req_type
// rsp     | out | digest_word[31:0], word_index[34:32], pad to 40 | tlast = last_word
//
// Each req handshake with req_type low takes one data byte. The byte that fills
// the block starts a compression made of load, schedule, round and update
// phases; the first round step only primes the registered read of the schedule
// memory. Finish writes the padding bytes, one per cycle, up to the end of the
// block, runs one or two such compressions, then emits eight result words.
// Reset is synchronous and active high and restores the initial hash.
// req_tready is low while padding, while a block compresses and while the digest
// is emitted; rsp stalls simply hold the current digest word.
module sha256_stream_hasher
   import sha_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte[7:0]
   input  logic        req_tuser,   // req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // digest_word[31:0], word_index[34:32], zeros
   output logic        rsp_tlast
);
   // Block buffer as 16 big-endian words; schedule memory of 64 words.
   logic [31:0] blk_mem [BlockWords];
   logic [31:0] w_mem   [Rounds];
   logic [31:0] hash_ff [8];
   logic [31:0] vars_ff [8];
   logic [31:0] vars_nx [8];
   logic [5:0]  fill_ff;
   logic [63:0] bits_ff;
   state_type   state_ff;
   logic [6:0]  cnt_ff;       // step within a phase
   logic        final_ff;     // the block being compressed is the last one
   logic        lenblk_ff;    // padding has reached the length block
   logic [2:0]  emit_ff;
   // Set while a finish is in progress, so a non-final block resumes padding.
   logic        padding_ff;
   // Schedule window: last 16 words kept in a shift line.
   logic [31:0] win_ff [16];
   logic [31:0] w_rd_ff;

   logic        in_fire, wr_byte;
   logic [7:0]  byte_val;
   logic [31:0] sched_new, p, q;
   logic [31:0] blk_word;
   logic [5:0]  k_idx;

   assign in_fire = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);

   // The round constant follows the schedule word, which lags cnt_ff by one.
   assign k_idx = cnt_ff[5:0] - 6'd1;

   sha_round u_round (.vars_in(vars_ff), .k_word(RoundK[k_idx]),
                      .w_word(w_rd_ff), .vars_out(vars_nx));

   always_comb begin
      p = win_ff[1];
      q = win_ff[14];
      sched_new = (ror(q, 17) ^ ror(q, 19) ^ (q >> 10)) + win_ff[9]
                + (ror(p, 7) ^ ror(p, 18) ^ (p >> 3)) + win_ff[0];
      wr_byte  = 1'b0;
      byte_val = req_tdata;
      if (state_ff == ST_IDLE && in_fire && !req_tuser) begin
         wr_byte = 1'b1;
      end else if (state_ff == ST_PAD) begin
         wr_byte = 1'b1;
         if (cnt_ff[0]) begin
            byte_val = PadByte;
         end else if (lenblk_ff && fill_ff[5:3] == 3'd7) begin
            byte_val = bits_ff[8 * (7 - fill_ff[2:0]) +: 8];
         end else begin
            byte_val = 8'h00;
         end
      end
      blk_word = blk_mem[fill_ff[5:2]];
      blk_word[8 * (3 - fill_ff[1:0]) +: 8] = byte_val;
   end

   always_ff @(posedge clock) begin
      if (wr_byte) blk_mem[fill_ff[5:2]] <= blk_word;
      if (state_ff == ST_LOAD) begin
         w_mem[cnt_ff[5:0]] <= blk_mem[cnt_ff[3:0]];
      end else if (state_ff == ST_SCHED) begin
         w_mem[cnt_ff[5:0]] <= sched_new;
      end
      w_rd_ff <= w_mem[cnt_ff[5:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         fill_ff   <= '0;
         bits_ff   <= '0;
         cnt_ff    <= '0;
         final_ff  <= 1'b0;
         lenblk_ff <= 1'b0;
         emit_ff   <= '0;
         for (int i = 0; i < 8; i++) hash_ff[i] <= InitHash[i];
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (in_fire && !req_tuser) begin
                  fill_ff <= fill_ff + 6'd1;
                  bits_ff <= bits_ff + 64'd8;
                  if (fill_ff == 6'd63) begin
                     state_ff <= ST_LOAD;
                     cnt_ff   <= '0;
                     final_ff <= 1'b0;
                  end
               end else if (in_fire) begin
                  state_ff  <= ST_PAD;
                  cnt_ff    <= 7'd1;   // first pad byte is 0x80
                  lenblk_ff <= (fill_ff < 6'd56);
               end
            end
            ST_PAD: begin
               cnt_ff  <= '0;
               fill_ff <= fill_ff + 6'd1;
               if (fill_ff == 6'd63) begin
                  state_ff <= ST_LOAD;
                  final_ff <= lenblk_ff;
               end
            end
            ST_LOAD: begin
               cnt_ff <= cnt_ff + 7'd1;
               if (cnt_ff == 7'd15) state_ff <= ST_SCHED;
               win_ff[15] <= blk_mem[cnt_ff[3:0]];
               for (int i = 0; i < 15; i++) win_ff[i] <= win_ff[i + 1];
            end
            ST_SCHED: begin
               win_ff[15] <= sched_new;
               for (int i = 0; i < 15; i++) win_ff[i] <= win_ff[i + 1];
               if (cnt_ff == 7'd63) begin
                  state_ff <= ST_ROUND;
                  cnt_ff   <= 7'd0;   // read of w[0] issued next cycle
                  vars_ff  <= hash_ff;
               end else begin
                  cnt_ff <= cnt_ff + 7'd1;
               end
            end
            ST_ROUND: begin
               // cnt_ff addresses the registered schedule read; w_rd_ff holds w[cnt_ff - 1].
               cnt_ff <= cnt_ff + 7'd1;
               if (cnt_ff != 7'd0) begin
                  vars_ff <= vars_nx;
               end
               if (cnt_ff == 7'd64) state_ff <= ST_UPDATE;
            end
            ST_UPDATE: begin
               for (int i = 0; i < 8; i++) hash_ff[i] <= hash_ff[i] + vars_ff[i];
               cnt_ff <= '0;
               if (final_ff) begin
                  state_ff <= ST_EMIT;
                  emit_ff  <= '0;
               end else if (padding_ff) begin
                  // Padding that overflowed into a second block continues here.
                  state_ff  <= ST_PAD;
                  lenblk_ff <= 1'b1;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_EMIT: begin
               if (rsp_tready) begin
                  emit_ff <= emit_ff + 3'd1;
                  if (emit_ff == 3'd7) begin
                     state_ff <= ST_IDLE;
                     fill_ff  <= '0;
                     bits_ff  <= '0;
                     for (int i = 0; i < 8; i++) hash_ff[i] <= InitHash[i];
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) padding_ff <= 1'b0;
      else if (state_ff == ST_IDLE && in_fire && req_tuser) padding_ff <= 1'b1;
      else if (state_ff == ST_EMIT && rsp_tready && emit_ff == 3'd7) padding_ff <= 1'b0;
   end

   assign rsp_tvalid = (state_ff == ST_EMIT);
   assign rsp_tdata  = {5'd0, emit_ff, hash_ff[emit_ff]};
   assign rsp_tlast  = (emit_ff == 3'd7);

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("input taken while emitting");
   a_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> !rsp_tvalid)
      else $error("digest ran past its last word");
   a_fill: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> padding_ff) else $error("emit without finish");
endmodule
